FILE: rtl/core/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check under an asynchronous active-low reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication check.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/bmpt_pkg.sv
`timescale 1ns / 1ps
package bmpt_pkg;

  localparam int unsigned AddrW  = 48;
  localparam int unsigned TickW  = 32;
  localparam int unsigned HitsW  = 32;
  localparam int unsigned OpW    = 3;
  localparam int unsigned SlotFW = 10;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 21;
  localparam int unsigned BbW    = 21;
  localparam int unsigned SiuW   = 11;
  localparam int unsigned CountW = 16;

  localparam logic [OpW-1:0] OpLookup   = 3'd0;
  localparam logic [OpW-1:0] OpMark     = 3'd1;
  localparam logic [OpW-1:0] OpBegin    = 3'd2;
  localparam logic [OpW-1:0] OpComplete = 3'd3;
  localparam logic [OpW-1:0] OpAbort    = 3'd4;

  localparam logic [CfgIdxW-1:0] CfgBlockBytes = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSlotsInUse = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgCaching    = 2'd2;

  // Marks bit positions.
  localparam int unsigned MkValid = 0;
  localparam int unsigned MkPop   = 1;
  localparam int unsigned MkAcc   = 2;

  // Controller to datapath.
  typedef struct packed {
    logic clr_wr;     // clear one slot of the table after reset
    logic load;       // capture input item
    logic div_step;   // one restoring divide step
    logic mod_init;   // start modulo of the quotient
    logic mod_step;   // one modulo step
    logic rd_issue;   // read entry at the current probe slot
    logic probe_adv;  // advance probe slot
    logic rd_target;  // read entry at the target slot
    logic wr_hit;     // write hit update at current probe slot
    logic wr_op;      // write the target-slot update
    logic set_hit;    // mark result as hit
    logic fin;        // load result register
  } bmpt_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [OpW-1:0] op;
    logic           caching;
    logic           n_zero;
    logic           in_range;
    logic           rd_match;
    logic           rd_empty;
    logic           target_pop;
    logic           clr_last;
  } bmpt_sts_t;

endpackage

FILE: rtl/core/bmpt_datapath.sv
`timescale 1ns / 1ps
module bmpt_datapath #(
  parameter int unsigned SLOTS = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bmpt_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [bmpt_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic [bmpt_pkg::OpW-1:0]           opcode_i,
  input  logic [bmpt_pkg::AddrW-1:0]         block_address_i,
  input  logic [bmpt_pkg::SlotFW-1:0]        slot_number_i,
  input  logic [bmpt_pkg::TickW-1:0]         now_tick_i,
  input  bmpt_pkg::bmpt_cmd_t                cmd_i,
  output bmpt_pkg::bmpt_sts_t                sts_o,
  output logic                               hit_o,
  output logic [bmpt_pkg::SlotFW-1:0]        found_slot_o,
  output logic                               acted_o,
  output logic [bmpt_pkg::AddrW-1:0]         displaced_address_o,
  output logic [bmpt_pkg::CountW-1:0]        filled_count_o
);
  import bmpt_pkg::*;

  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned NW = $clog2(SLOTS + 1);
  localparam int unsigned MemW = AddrW + TickW + HitsW;

  // Configuration.
  logic [BbW-1:0]  bb_q;
  logic [SiuW-1:0] siu_q;
  logic            cache_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bb_q    <= BbW'(4096);
      siu_q   <= '0;
      cache_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgBlockBytes: bb_q    <= cfg_data_i[BbW-1:0];
        CfgSlotsInUse: siu_q   <= cfg_data_i[SiuW-1:0];
        CfgCaching:    cache_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [BbW-1:0] div_v;
  logic [NW-1:0]  n_v;
  assign div_v = (bb_q == '0) ? BbW'(1) : bb_q;
  assign n_v   = (32'(siu_q) > SLOTS) ? NW'(SLOTS) : NW'(siu_q);

  // Captured item.
  logic [OpW-1:0]    op_q;
  logic [AddrW-1:0]  addr_q;
  logic [SlotFW-1:0] slot_q;
  logic [TickW-1:0]  tick_q;

  // Restoring divider: quotient shifts into quo_q, remainder in rem_q.
  logic [AddrW-1:0] quo_q;
  logic [BbW:0]     rem_q;
  logic [BbW:0]     rem_sh;
  logic             rem_ge;

  assign rem_sh = {rem_q[BbW-1:0], quo_q[AddrW-1]};
  assign rem_ge = rem_sh >= {1'b0, div_v};

  // Modulo of quotient by n: bit-serial, remainder stays below n.
  logic [AddrW-1:0] mq_q;
  logic [NW:0]      mr_q;
  logic [NW:0]      mr_sh;
  logic [NW:0]      mr_d;
  assign mr_sh = {mr_q[NW-1:0], mq_q[AddrW-1]};
  assign mr_d  = (mr_sh >= {1'b0, n_v}) ? (mr_sh - {1'b0, n_v}) : mr_sh;

  // Probe slot.
  logic [NW-1:0] ps_q;
  logic [NW-1:0] ps_inc;
  assign ps_inc = ps_q + NW'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= opcode_i;
      addr_q <= block_address_i;
      slot_q <= slot_number_i;
      tick_q <= now_tick_i;
      quo_q  <= block_address_i;
      rem_q  <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[AddrW-2:0], rem_ge};
      rem_q <= rem_ge ? (rem_sh - {1'b0, div_v}) : rem_sh;
    end
    if (cmd_i.mod_init) begin
      mq_q <= quo_q;
      mr_q <= '0;
    end else if (cmd_i.mod_step) begin
      mq_q <= {mq_q[AddrW-2:0], 1'b0};
      mr_q <= mr_d;
    end
    if (cmd_i.mod_init) begin
      ps_q <= '0;
    end else if (cmd_i.probe_adv) begin
      ps_q <= (ps_inc >= n_v) ? '0 : ps_inc;
    end else if (cmd_i.mod_step) begin
      ps_q <= mr_d[NW-1:0];
    end
  end

  // Clearing pass after reset walks every slot once.
  logic [SW-1:0] clr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else if (cmd_i.clr_wr) clr_q <= clr_q + SW'(1);
  end

  // Table memory: address, tick, hits in one RAM; marks in a second RAM.
  logic [MemW-1:0] mem_q [SLOTS];
  logic [2:0]      marks_q [SLOTS];
  logic [MemW-1:0] rd_q;
  logic [2:0]      rdm_q;
  logic [SW-1:0]   rd_sl_q;
  logic [SW-1:0]   rd_addr;
  logic            rd_tgt;

  assign rd_tgt  = cmd_i.rd_target;
  assign rd_addr = rd_tgt ? SW'(slot_q) : ps_q[SW-1:0];

  logic [AddrW-1:0] rd_a;
  logic [HitsW-1:0] rd_h;
  assign rd_a = rd_q[MemW-1 -: AddrW];
  assign rd_h = rd_q[HitsW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_issue || cmd_i.rd_target) begin
      rd_q    <= mem_q[rd_addr];
      rd_sl_q <= rd_addr;
    end
    if (cmd_i.clr_wr) begin
      mem_q[clr_q] <= '0;
    end else if (cmd_i.wr_hit) begin
      mem_q[rd_sl_q] <= {rd_a, tick_q, rd_h + HitsW'(1)};
    end else if (cmd_i.wr_op) begin
      if (op_q == OpMark) begin
        mem_q[rd_sl_q] <= {rd_a, tick_q, rd_h};
      end else if (op_q == OpComplete) begin
        mem_q[rd_sl_q] <= {addr_q, tick_q, {HitsW{1'b0}}};
      end
    end
  end

  // New marks for the slot just read.
  logic [2:0] mk_acc, mk_begin, mk_fill, mk_abort;
  always_comb begin
    mk_acc            = rdm_q;
    mk_acc[MkAcc]     = 1'b1;
    mk_begin          = rdm_q;
    mk_begin[MkValid] = 1'b0;
    mk_begin[MkPop]   = 1'b1;
    mk_fill           = '0;
    mk_fill[MkValid]  = 1'b1;
    mk_fill[MkAcc]    = 1'b1;
    mk_abort          = rdm_q;
    mk_abort[MkValid] = 1'b0;
    mk_abort[MkPop]   = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_issue || cmd_i.rd_target) rdm_q <= marks_q[rd_addr];
    if (cmd_i.clr_wr) begin
      marks_q[clr_q] <= '0;
    end else if (cmd_i.wr_hit) begin
      marks_q[rd_sl_q] <= mk_acc;
    end else if (cmd_i.wr_op) begin
      case (op_q)
        OpMark:     marks_q[rd_sl_q] <= mk_acc;
        OpBegin:    marks_q[rd_sl_q] <= mk_begin;
        OpComplete: marks_q[rd_sl_q] <= mk_fill;
        OpAbort:    marks_q[rd_sl_q] <= mk_abort;
        default: ;
      endcase
    end
  end

  // Fill counter.
  logic [CountW-1:0] fills_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fills_q <= '0;
    else if (cmd_i.wr_op && op_q == OpComplete && fills_q != '1)
      fills_q <= fills_q + CountW'(1);
  end

  // Result register.
  logic hit_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) hit_q <= 1'b0;
    else if (cmd_i.set_hit) hit_q <= 1'b1;
  end
  logic acted_w;
  assign acted_w = cmd_i.set_hit || cmd_i.wr_op;
  logic acted_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) acted_q <= 1'b0;
    else if (acted_w) acted_q <= 1'b1;
  end
  logic [SlotFW-1:0] fslot_q;
  logic [AddrW-1:0]  disp_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      fslot_q <= '0;
      disp_q  <= '0;
    end else begin
      if (cmd_i.set_hit) fslot_q <= SlotFW'(rd_sl_q);
      if (cmd_i.wr_op && op_q == OpBegin) disp_q <= rd_a;
    end
  end

  logic              o_hit_q, o_acted_q;
  logic [SlotFW-1:0] o_slot_q;
  logic [AddrW-1:0]  o_disp_q;
  logic [CountW-1:0] o_count_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      o_hit_q   <= hit_q;
      o_acted_q <= acted_q;
      o_slot_q  <= fslot_q;
      o_disp_q  <= disp_q;
      o_count_q <= fills_q;
    end
  end

  assign hit_o               = o_hit_q;
  assign found_slot_o        = o_slot_q;
  assign acted_o             = o_acted_q;
  assign displaced_address_o = o_disp_q;
  assign filled_count_o      = o_count_q;

  assign sts_o.op         = op_q;
  assign sts_o.caching    = cache_q;
  assign sts_o.n_zero     = (n_v == '0);
  assign sts_o.in_range   = ({1'b0, slot_q} < (SlotFW+1)'(n_v)) && (32'(slot_q) < SLOTS);
  assign sts_o.rd_match   = rdm_q[MkValid] && !rdm_q[MkPop] && (rd_a == addr_q);
  assign sts_o.rd_empty   = !rdm_q[MkValid] && !rdm_q[MkPop];
  assign sts_o.target_pop = rdm_q[MkPop];
  assign sts_o.clr_last   = (clr_q == SW'(SLOTS - 1));

endmodule

FILE: rtl/core/bmpt_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bmpt_ctrl #(
  parameter int unsigned PROBE_MAX = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  bmpt_pkg::bmpt_sts_t sts_i,
  output bmpt_pkg::bmpt_cmd_t cmd_o
);
  import bmpt_pkg::*;

  localparam int unsigned CW = 6;
  localparam int unsigned PW = $clog2(PROBE_MAX + 1);

  typedef enum logic [3:0] {
    StClr, StIdle, StDiv, StModInit, StMod, StRd, StChk, StTgtRd, StTgt, StFin
  } state_e;

  state_e          state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [PW-1:0]   pc_q, pc_d;
  logic            ov_q, ov_d;
  bmpt_cmd_t       cmd;

  logic accept, out_take;
  assign accept   = in_valid_i && !in_stall_o;
  assign out_take = ov_q && !out_stall_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    pc_d    = pc_q;
    ov_d    = out_take ? 1'b0 : ov_q;
    cmd     = '0;
    unique case (state_q)
      StClr: begin
        cmd.clr_wr = 1'b1;
        if (sts_i.clr_last) state_d = StIdle;
      end
      StIdle: begin
        if (accept) begin
          cmd.load = 1'b1;
          state_d  = StDiv;
          cnt_d    = '0;
        end
      end
      StDiv: begin
        if ((sts_i.op == OpLookup) || (sts_i.op == OpBegin && sts_i.caching)) begin
          if (sts_i.n_zero) begin
            state_d = (sts_i.op == OpBegin) ? StTgtRd : StFin;
          end else begin
            cmd.div_step = 1'b1;
            cnt_d = cnt_q + CW'(1);
            if (cnt_q == CW'(AddrW - 1)) state_d = StModInit;
          end
        end else if (sts_i.op == OpMark || sts_i.op == OpComplete || sts_i.op == OpAbort) begin
          state_d = StTgtRd;
        end else begin
          state_d = StFin;
        end
      end
      StModInit: begin
        cmd.mod_init = 1'b1;
        cnt_d   = '0;
        state_d = StMod;
      end
      StMod: begin
        cmd.mod_step = 1'b1;
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(AddrW - 1)) begin
          state_d = StRd;
          pc_d    = '0;
        end
      end
      StRd: begin
        cmd.rd_issue = 1'b1;
        state_d = StChk;
      end
      StChk: begin
        if (sts_i.rd_match) begin
          cmd.wr_hit  = 1'b1;
          cmd.set_hit = 1'b1;
          state_d = StFin;
        end else if (sts_i.rd_empty || pc_q == PW'(PROBE_MAX - 1)) begin
          state_d = (sts_i.op == OpBegin) ? StTgtRd : StFin;
        end else begin
          cmd.probe_adv = 1'b1;
          pc_d    = pc_q + PW'(1);
          state_d = StRd;
        end
      end
      StTgtRd: begin
        if (sts_i.in_range && (sts_i.op == OpMark || sts_i.caching)) begin
          cmd.rd_target = 1'b1;
          state_d = StTgt;
        end else begin
          state_d = StFin;
        end
      end
      StTgt: begin
        if (sts_i.op == OpMark || sts_i.op == OpBegin || sts_i.target_pop) begin
          cmd.wr_op = 1'b1;
        end
        state_d = StFin;
      end
      StFin: begin
        if (!ov_q || out_take) begin
          cmd.fin = 1'b1;
          ov_d    = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClr;
      cnt_q   <= '0;
      pc_q    <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pc_q    <= pc_d;
      ov_q    <= ov_d;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = ov_q;
  assign cmd_o       = cmd;

  `ASSERT_IMPL(a_one_write, clk_i, rst_ni, cmd.wr_hit, !cmd.wr_op)
  `ASSERT_NEXT(a_fin_valid, clk_i, rst_ni, cmd.fin, out_valid_o)
  `ASSERT_IMPL(a_probe_bound, clk_i, rst_ni, state_q == StChk, pc_q < PW'(PROBE_MAX))

endmodule

FILE: rtl/core/block_map_probe_table.sv
`timescale 1ns / 1ps
// Block map with linear-probing lookup.
// Input channel: in_valid_i / in_stall_o with opcode, block address, slot
// number and tick. Output channel: out_valid_o / out_stall_i with hit,
// found slot, acted, displaced address and fill count. One result per item.
// Configuration: cfg_valid_i / cfg_ready_o, index and data; write only idle.
// Lookup, and begin fill with caching on, run the divide steps (address by
// block size), a setup state, the modulo steps (block number by slots in
// use), a read and a check per probe up to PROBE_MAX probes, a victim slot
// read and write when a begin fill misses, and the load of the result.
// Other items skip the divide and modulo steps. The input takes the next
// item in the cycle after the result is loaded.
// One item is in flight at a time; the result register lets the next item
// enter while the previous result waits to be taken.
// After reset the block clears one slot per cycle with in_stall_o held
// high; configuration returns to block size 4096, no slots in use,
// caching on, and the fill count to zero.
// While the receiver stalls, the result holds and the block finishes the
// item in flight, then waits before delivering the next result.
module block_map_probe_table #(
  parameter int unsigned SLOTS     = 1024,
  parameter int unsigned PROBE_MAX = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bmpt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bmpt_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [bmpt_pkg::OpW-1:0]      opcode_i,
  input  logic [bmpt_pkg::AddrW-1:0]    block_address_i,
  input  logic [bmpt_pkg::SlotFW-1:0]   slot_number_i,
  input  logic [bmpt_pkg::TickW-1:0]    now_tick_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          hit_o,
  output logic [bmpt_pkg::SlotFW-1:0]   found_slot_o,
  output logic                          acted_o,
  output logic [bmpt_pkg::AddrW-1:0]    displaced_address_o,
  output logic [bmpt_pkg::CountW-1:0]   filled_count_o
);
  import bmpt_pkg::*;

  bmpt_cmd_t cmd;
  bmpt_sts_t sts;

  assign cfg_ready_o = 1'b1;

  bmpt_ctrl #(.PROBE_MAX(PROBE_MAX)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  bmpt_datapath #(.SLOTS(SLOTS)) u_dp (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_valid_i && cfg_ready_o), .cfg_idx_i(cfg_index_i),
    .cfg_data_i(cfg_data_i),
    .opcode_i, .block_address_i, .slot_number_i, .now_tick_i,
    .cmd_i(cmd), .sts_o(sts),
    .hit_o, .found_slot_o, .acted_o, .displaced_address_o, .filled_count_o
  );

endmodule
